FILE: rtl/core/crp_pkg.sv
package crp_pkg;

  localparam int PIX_W     = 12;
  localparam int DIM_CFG_W = 13;
  localparam int RING_CFG_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam int COLOR_W   = 8;
  localparam int V_QUO_W   = 8;
  localparam int COLOR_MAX = 255;

  localparam logic [DIM_CFG_W-1:0]  RST_FRAME_WIDTH  = 13'd400;
  localparam logic [DIM_CFG_W-1:0]  RST_FRAME_HEIGHT = 13'd300;
  localparam logic [RING_CFG_W-1:0] RST_RING_WIDTH   = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_RING_WIDTH   = 2'd2
  } cfg_idx_t;

endpackage

FILE: rtl/core/concentric_ring_pattern_pixel_top.sv
// Pipeline: stage A, stage B, RW root cells, the bridge, VQ v cells, RQ ring cells and output,
//   where RW = root bits of the distance (21), RQ = ring index bits (12), VQ = v quotient bits.
// Throughput: one item per cycle; the whole cell chain advances together and
//   holds while a finished result is not taken.
// Reset (rst_n, synchronous, active low): clears all valid bits and loads the
//   frame registers with 400 x 300 and ring width 20.
module concentric_ring_pattern_pixel_top #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [crp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [crp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [crp_pkg::PIX_W-1:0]          in_pixel_x,
  input  logic [crp_pkg::PIX_W-1:0]          in_pixel_y,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_inside_disc,
  output logic [crp_pkg::COLOR_W-1:0]        out_red,
  output logic [crp_pkg::COLOR_W-1:0]        out_green,
  output logic [crp_pkg::COLOR_W-1:0]        out_blue
);

  // Widths derived from the frame limit and the fraction width.
  localparam int F    = FRAC_BITS;
  localparam int DW   = $clog2(MAX_DIM + 1);               // saturated dimension
  localparam int DXW  = (DW - 1 > crp_pkg::PIX_W) ? DW - 1 : crp_pkg::PIX_W;
  localparam int SQW  = 2 * DXW + 1;                       // dx^2 + dy^2
  localparam int RW   = (SQW + 2 * F + 1) / 2;             // root bits
  localparam int RFW  = DW - 1 + F;                        // radius, fixed point
  localparam int RDW  = crp_pkg::RING_CFG_W + F;           // ring span, fixed point
  localparam int RQ   = DW - 1;                            // ring index bits
  localparam int VNW  = RFW + crp_pkg::COLOR_W;            // 255 * (R - d)
  localparam int VQ   = crp_pkg::V_QUO_W;
  localparam int SSW  = RFW + RDW;                         // side data in root chain
  localparam int VSW  = 1 + RDW;                           // side data in v chain
  localparam int GSW  = 1 + VQ;                            // side data in ring chain

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [crp_pkg::DIM_CFG_W-1:0]  frame_width_r;
  logic [crp_pkg::DIM_CFG_W-1:0]  frame_height_r;
  logic [crp_pkg::RING_CFG_W-1:0] ring_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= crp_pkg::RST_FRAME_WIDTH;
      frame_height_r <= crp_pkg::RST_FRAME_HEIGHT;
      ring_width_r   <= crp_pkg::RST_RING_WIDTH;
    end else if (cfg_we) begin
      unique case (crp_pkg::cfg_idx_t'(cfg_index))
        crp_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        crp_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        crp_pkg::CFG_RING_WIDTH:   ring_width_r   <= cfg_wdata[crp_pkg::RING_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Whole chain moves in lockstep; hold everything while the result waits.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------------------------------------------------------------------
  // Stage A: saturate the frame, find the centre offsets and the scaled limits
  // ---------------------------------------------------------------------------
  logic [DW-1:0]  w_sat;
  logic [DW-1:0]  h_sat;
  logic [DW-2:0]  radius;
  logic [DXW-1:0] px_e, py_e, cx_e, cy_e;
  logic [RDW-1:0] rden;

  always_comb begin
    w_sat = (32'(frame_width_r) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(frame_width_r);
    h_sat = (32'(frame_height_r) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(frame_height_r);
    radius = (w_sat < h_sat) ? w_sat[DW-1:1] : h_sat[DW-1:1];
    px_e = DXW'(in_pixel_x);
    py_e = DXW'(in_pixel_y);
    cx_e = DXW'(w_sat[DW-1:1]);
    cy_e = DXW'(h_sat[DW-1:1]);
    // Zero ring width acts as one pixel.
    rden = RDW'((ring_width_r == '0) ? crp_pkg::RING_CFG_W'(1) : ring_width_r) << F;
  end

  logic           a_vld_r;
  logic [DXW-1:0] a_dx_r, a_dy_r;
  logic [RFW-1:0] a_rfix_r;
  logic [RDW-1:0] a_rden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx_r   <= (px_e >= cx_e) ? px_e - cx_e : cx_e - px_e;
      a_dy_r   <= (py_e >= cy_e) ? py_e - cy_e : cy_e - py_e;
      a_rfix_r <= RFW'(radius) << F;
      a_rden_r <= rden;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: squares
  // ---------------------------------------------------------------------------
  logic             b_vld_r;
  logic [2*DXW-1:0] b_dx2_r, b_dy2_r;
  logic [RFW-1:0]   b_rfix_r;
  logic [RDW-1:0]   b_rden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dx2_r  <= a_dx_r * a_dx_r;
      b_dy2_r  <= a_dy_r * a_dy_r;
      b_rfix_r <= a_rfix_r;
      b_rden_r <= a_rden_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Square root chain: one cell per root bit, radicand scaled by 2^(2F)
  // ---------------------------------------------------------------------------
  logic [SQW-1:0] sq;
  assign sq = SQW'(b_dx2_r) + SQW'(b_dy2_r);

  logic            s_vld  [0:RW];
  logic [RW+1:0]   s_rem  [0:RW];
  logic [RW-1:0]   s_root [0:RW];
  logic [2*RW-1:0] s_bits [0:RW];
  logic [SSW-1:0]  s_side [0:RW];

  assign s_vld[0]  = b_vld_r;
  assign s_rem[0]  = '0;
  assign s_root[0] = '0;
  assign s_bits[0] = (2 * RW)'(sq) << (2 * F);
  assign s_side[0] = {b_rfix_r, b_rden_r};

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    crp_sqrt_cell #(.RW(RW), .SW(SSW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (s_vld[i]),
      .in_rem   (s_rem[i]),
      .in_root  (s_root[i]),
      .in_bits  (s_bits[i]),
      .in_side  (s_side[i]),
      .out_vld  (s_vld[i+1]),
      .out_rem  (s_rem[i+1]),
      .out_root (s_root[i+1]),
      .out_bits (s_bits[i+1]),
      .out_side (s_side[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Bridge: disc test and v numerator 255 * (R - d)
  // ---------------------------------------------------------------------------
  logic [RFW-1:0] s_rfix;
  logic [RDW-1:0] s_rden;
  logic [RW-1:0]  dist_fix;
  logic           disc_hit;
  logic [RFW-1:0] dist_t;
  logic [RFW-1:0] diff;

  assign {s_rfix, s_rden} = s_side[RW];
  assign dist_fix = s_root[RW];
  assign disc_hit = (RW > RFW) ? (dist_fix < RW'(s_rfix)) : (RFW'(dist_fix) < s_rfix);
  assign dist_t   = RFW'(dist_fix);
  assign diff     = s_rfix - dist_t;

  logic           m_vld_r;
  logic           m_inside_r;
  logic [VNW-1:0] m_vnum_r;
  logic [RFW-1:0] m_rfix_r;
  logic [RFW-1:0] m_dist_r;
  logic [RDW-1:0] m_rden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= s_vld[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_inside_r <= disc_hit;
      // 255 * diff as (diff << 8) - diff
      m_vnum_r   <= (VNW'(diff) << crp_pkg::COLOR_W) - VNW'(diff);
      m_rfix_r   <= s_rfix;
      m_dist_r   <= dist_t;
      m_rden_r   <= s_rden;
    end
  end

  // ---------------------------------------------------------------------------
  // v = floor(255 * (R - d) / R): one cell per quotient bit
  // ---------------------------------------------------------------------------
  logic           v_vld  [0:VQ];
  logic [VNW-1:0] v_num  [0:VQ];
  logic [RFW-1:0] v_den  [0:VQ];
  logic [VQ-1:0]  v_quo  [0:VQ];
  logic [RFW+VSW-1:0] v_side [0:VQ];

  assign v_vld[0]  = m_vld_r;
  assign v_num[0]  = m_vnum_r;
  assign v_den[0]  = m_rfix_r;
  assign v_quo[0]  = '0;
  assign v_side[0] = {m_inside_r, m_rden_r, m_dist_r};

  for (genvar j = 0; j < VQ; j++) begin : g_vdiv
    crp_div_cell #(
      .NUMW (VNW), .DENW (RFW), .QW (VQ), .SHIFT (VQ - 1 - j), .SW (RFW + VSW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (v_vld[j]),
      .in_num   (v_num[j]),
      .in_den   (v_den[j]),
      .in_quo   (v_quo[j]),
      .in_side  (v_side[j]),
      .out_vld  (v_vld[j+1]),
      .out_num  (v_num[j+1]),
      .out_den  (v_den[j+1]),
      .out_quo  (v_quo[j+1]),
      .out_side (v_side[j+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Ring index = floor(d / ring span): only its parity is used
  // ---------------------------------------------------------------------------
  logic           v_inside;
  logic [RDW-1:0] v_rden;
  logic [RFW-1:0] v_dist;

  assign {v_inside, v_rden, v_dist} = v_side[VQ];

  logic           g_vld  [0:RQ];
  logic [RFW-1:0] g_num  [0:RQ];
  logic [RDW-1:0] g_den  [0:RQ];
  logic [RQ-1:0]  g_quo  [0:RQ];
  logic [GSW-1:0] g_side [0:RQ];

  assign g_vld[0]  = v_vld[VQ];
  assign g_num[0]  = v_dist;
  assign g_den[0]  = v_rden;
  assign g_quo[0]  = '0;
  assign g_side[0] = {v_inside, v_quo[VQ]};

  for (genvar k = 0; k < RQ; k++) begin : g_rdiv
    crp_div_cell #(
      .NUMW (RFW), .DENW (RDW), .QW (RQ), .SHIFT (RQ - 1 - k), .SW (GSW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (g_vld[k]),
      .in_num   (g_num[k]),
      .in_den   (g_den[k]),
      .in_quo   (g_quo[k]),
      .in_side  (g_side[k]),
      .out_vld  (g_vld[k+1]),
      .out_num  (g_num[k+1]),
      .out_den  (g_den[k+1]),
      .out_quo  (g_quo[k+1]),
      .out_side (g_side[k+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: pick the color scheme by ring parity, black outside
  // ---------------------------------------------------------------------------
  logic        f_inside;
  logic [VQ-1:0] f_v;
  logic [crp_pkg::COLOR_W-1:0] v8, v_half, v_inv;

  assign {f_inside, f_v} = g_side[RQ];
  assign v8     = crp_pkg::COLOR_W'(f_v);
  assign v_half = v8 >> 1;
  assign v_inv  = crp_pkg::COLOR_W'(crp_pkg::COLOR_MAX) - v8;

  logic                        out_valid_r;
  logic                        out_inside_r;
  logic [crp_pkg::COLOR_W-1:0] out_red_r, out_green_r, out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= g_vld[RQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_r <= f_inside;
      if (!f_inside) begin
        out_red_r   <= '0;
        out_green_r <= '0;
        out_blue_r  <= '0;
      end else if (!g_quo[RQ][0]) begin
        out_red_r   <= v8;
        out_green_r <= v_half;
        out_blue_r  <= v_inv;
      end else begin
        out_red_r   <= v_inv;
        out_green_r <= v8;
        out_blue_r  <= v_half;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_inside_disc = out_inside_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;

endmodule

FILE: rtl/core/crp_sqrt_cell.sv
// One root bit per cell: bring down two radicand bits, try to subtract.
module crp_sqrt_cell #(
  parameter int RW = 22,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [RW+1:0]   in_rem,
  input  logic [RW-1:0]   in_root,
  input  logic [2*RW-1:0] in_bits,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [RW+1:0]   out_rem,
  output logic [RW-1:0]   out_root,
  output logic [2*RW-1:0] out_bits,
  output logic [SW-1:0]   out_side
);

  logic [RW+1:0] cur;
  logic [RW+1:0] trial;
  logic          ge;
  logic          vld_r;
  logic [RW+1:0] rem_r;
  logic [RW-1:0] root_r;
  logic [2*RW-1:0] bits_r;
  logic [SW-1:0] side_r;

  assign cur   = {in_rem[RW-1:0], in_bits[2*RW-1 -: 2]};
  assign trial = {in_root, 2'b01};
  assign ge    = cur >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= ge ? (cur - trial) : cur;
      root_r <= {in_root[RW-2:0], ge};
      bits_r <= in_bits << 2;
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_rem  = rem_r;
  assign out_root = root_r;
  assign out_bits = bits_r;
  assign out_side = side_r;

endmodule

FILE: rtl/core/crp_div_cell.sv
// One quotient bit per cell: compare against the shifted divisor, subtract.
module crp_div_cell #(
  parameter int NUMW  = 20,
  parameter int DENW  = 12,
  parameter int QW    = 8,
  parameter int SHIFT = 0,
  parameter int SW    = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_vld,
  input  logic [NUMW-1:0] in_num,
  input  logic [DENW-1:0] in_den,
  input  logic [QW-1:0]   in_quo,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [NUMW-1:0] out_num,
  output logic [DENW-1:0] out_den,
  output logic [QW-1:0]   out_quo,
  output logic [SW-1:0]   out_side
);

  localparam int CW = (NUMW > DENW + SHIFT) ? NUMW : DENW + SHIFT;

  logic [CW-1:0] num_c;
  logic [CW-1:0] den_s;
  logic          ge;
  logic          vld_r;
  logic [NUMW-1:0] num_r;
  logic [DENW-1:0] den_r;
  logic [QW-1:0]   quo_r;
  logic [SW-1:0]   side_r;

  assign num_c = CW'(in_num);
  assign den_s = CW'(in_den) << SHIFT;
  assign ge    = num_c >= den_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= ge ? NUMW'(num_c - den_s) : in_num;
      den_r  <= in_den;
      quo_r  <= {in_quo[QW-2:0], ge};
      side_r <= in_side;
    end
  end

  assign out_vld  = vld_r;
  assign out_num  = num_r;
  assign out_den  = den_r;
  assign out_quo  = quo_r;
  assign out_side = side_r;

endmodule
